[sv/dhkt_pkg.sv]
package dhkt_pkg;

	localparam int SLOTS_DEF         = 1024;
	localparam int MAX_KEY_BYTES_DEF = 32;
	localparam int SIZE_W            = 10;
	localparam int HASH_W            = 32;
	localparam int VALUE_W           = 32;
	localparam int DIV_CNT_W         = $clog2(HASH_W);
	localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd1021;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 10'd3;
	localparam logic [HASH_W-1:0] FNV_BASIS  = 32'h811C9DC5;
	localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h01000193;

	typedef enum logic [2:0] {
		RSP_FOUND     = 3'd0,
		RSP_INSERTED  = 3'd1,
		RSP_NOT_FOUND = 3'd2,
		RSP_FULL      = 3'd3,
		RSP_TOO_LONG  = 3'd4
	} rsp_code_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ABSORB,
		S_DIVIDE,
		S_HOME,
		S_READ,
		S_CHECK,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		logic [63:0]         key_chunk;
		logic [3:0]          chunk_bytes;
		logic                key_end;
		logic                opcode;
		logic [VALUE_W-1:0]  entry_value;
	} req_beat_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [SIZE_W-1:0]   slot_index;
		logic [VALUE_W-1:0]  stored_value;
	} rsp_beat_t;

	typedef struct packed {
		logic clr_init;
		logic clr_step;
		logic load;
		logic absorb;
		logic div_init;
		logic div_step;
		logic home;
		logic check;
		logic next;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic abs_done;
		logic last;
		logic too_long;
		logic div_done;
		logic hit;
		logic exhausted;
		logic out_free;
	} dp_stat_t;

endpackage

[sv/double_hash_key_table.sv]
// channel | dir | handshake              | beat
// req     | in  | req_valid / req_stall  | key chunk, byte count, end, opcode, value
// rsp     | out | rsp_valid / rsp_stall  | status, slot index, stored value
// cfg     | in  | APB, reg 0 table_size  | 32-bit data
// A chunk's bytes are absorbed before the next beat is taken; a key's last chunk adds
// the remainder steps, the home slot, a read and check per probed slot and the result post.
// After reset and after each table_size write the slot store is swept,
// with req_stall high.
// The result sits in an output register; the next beat is taken while it waits.
module double_hash_key_table #(
	parameter int SLOTS         = dhkt_pkg::SLOTS_DEF,
	parameter int MAX_KEY_BYTES = dhkt_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  dhkt_pkg::req_beat_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output dhkt_pkg::rsp_beat_t  rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int SW = dhkt_pkg::SIZE_W;

	logic [SW-1:0]      table_size_q, size_wr;
	logic               cfg_we;
	dhkt_pkg::ctl_cmd_t cmd;
	dhkt_pkg::dp_stat_t stat;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && !paddr[2];
	assign prdata  = paddr[2] ? 32'd0 : {{(32-SW){1'b0}}, table_size_q};

	always_comb begin
		size_wr = pwdata[SW-1:0];
		if (size_wr < dhkt_pkg::SIZE_MIN) size_wr = dhkt_pkg::SIZE_MIN;
		else if ({{(32-SW){1'b0}}, size_wr} > 32'(SLOTS - 1)) size_wr = SW'(SLOTS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= dhkt_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			table_size_q <= size_wr;
		end
	end

	dhkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.req_valid (req_valid),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	dhkt_dp #(
		.SLOTS         (SLOTS),
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req        (req),
		.table_size (table_size_q),
		.rsp_stall  (rsp_stall),
		.stat       (stat),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp)
	);

`ifndef ASSERT_OFF
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> req_stall) else $error("no sweep after size write");
	a_slot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.slot_index != '0) ==
		(rsp.status == dhkt_pkg::RSP_FOUND || rsp.status == dhkt_pkg::RSP_INSERTED)))
		else $error("slot index disagrees with status");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.slot_index <= table_size_q))
		else $error("slot beyond table size");
`endif

endmodule

[sv/dhkt_ctrl.sv]
module dhkt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                req_valid,
	input  dhkt_pkg::dp_stat_t  stat,
	output logic                req_stall,
	output dhkt_pkg::ctl_cmd_t  cmd
);

	dhkt_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhkt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dhkt_pkg::S_CLEAR: begin
				if (stat.clr_done) state_d = dhkt_pkg::S_IDLE;
			end
			dhkt_pkg::S_IDLE: begin
				if (req_valid) state_d = dhkt_pkg::S_ABSORB;
			end
			dhkt_pkg::S_ABSORB: begin
				if (stat.abs_done) begin
					if (!stat.last) state_d = dhkt_pkg::S_IDLE;
					else if (stat.too_long) state_d = dhkt_pkg::S_FINISH;
					else state_d = dhkt_pkg::S_DIVIDE;
				end
			end
			dhkt_pkg::S_DIVIDE: begin
				if (stat.div_done) state_d = dhkt_pkg::S_HOME;
			end
			dhkt_pkg::S_HOME: state_d = dhkt_pkg::S_READ;
			dhkt_pkg::S_READ: state_d = dhkt_pkg::S_CHECK;
			dhkt_pkg::S_CHECK: begin
				if (stat.hit || stat.exhausted) state_d = dhkt_pkg::S_FINISH;
				else state_d = dhkt_pkg::S_READ;
			end
			dhkt_pkg::S_FINISH: begin
				if (stat.out_free) state_d = dhkt_pkg::S_IDLE;
			end
			default: state_d = dhkt_pkg::S_CLEAR;
		endcase
		if (cfg_we) state_d = dhkt_pkg::S_CLEAR;
	end

	always_comb begin
		cmd          = '0;
		cmd.clr_init = cfg_we;
		cmd.clr_step = (state_q == dhkt_pkg::S_CLEAR) && !cfg_we;
		cmd.load     = (state_q == dhkt_pkg::S_IDLE) && req_valid;
		cmd.absorb   = (state_q == dhkt_pkg::S_ABSORB) && !stat.abs_done;
		cmd.div_init = (state_q == dhkt_pkg::S_ABSORB) && stat.abs_done && stat.last
			&& !stat.too_long;
		cmd.div_step = (state_q == dhkt_pkg::S_DIVIDE);
		cmd.home     = (state_q == dhkt_pkg::S_HOME);
		cmd.check    = (state_q == dhkt_pkg::S_CHECK);
		cmd.next     = (state_q == dhkt_pkg::S_CHECK) && !stat.hit && !stat.exhausted;
		cmd.finish   = (state_q == dhkt_pkg::S_FINISH) && stat.out_free;
		req_stall    = (state_q != dhkt_pkg::S_IDLE);
	end

endmodule

[sv/dhkt_dp.sv]
module dhkt_dp #(
	parameter int SLOTS         = dhkt_pkg::SLOTS_DEF,
	parameter int MAX_KEY_BYTES = dhkt_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dhkt_pkg::ctl_cmd_t              cmd,
	input  dhkt_pkg::req_beat_t             req,
	input  logic [dhkt_pkg::SIZE_W-1:0]     table_size,
	input  logic                            rsp_stall,
	output dhkt_pkg::dp_stat_t              stat,
	output logic                            rsp_valid,
	output dhkt_pkg::rsp_beat_t             rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int SW = dhkt_pkg::SIZE_W;
	localparam int AW = (IW > SW) ? IW : SW;
	localparam int KW = MAX_KEY_BYTES * 8;
	localparam int LW = $clog2(MAX_KEY_BYTES + 2);
	localparam int HW = dhkt_pkg::HASH_W;
	localparam int VW = dhkt_pkg::VALUE_W;
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_KEY_BYTES);

	logic [HW-1:0] mem_hash [SLOTS];
	logic [KW-1:0] mem_key  [SLOTS];
	logic [LW-1:0] mem_len  [SLOTS];
	logic [VW-1:0] mem_val  [SLOTS];

	logic [HW-1:0] rd_hash_q;
	logic [KW-1:0] rd_key_q;
	logic [LW-1:0] rd_len_q;
	logic [VW-1:0] rd_val_q;

	logic [IW-1:0]  clr_addr_q;
	logic [SW-1:0]  count_q;
	logic [63:0]    chunk_q;
	logic [3:0]     nb_q;
	logic [3:0]     byte_cnt_q;
	logic           last_q, enter_q;
	logic [VW-1:0]  value_q;
	logic [KW-1:0]  key_buf_q;
	logic [LW-1:0]  len_q;
	logic [HW-1:0]  hash_q;
	logic [HW-1:0]  h_q;
	logic [dhkt_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [SW-1:0]  rem_a_q, rem_b_q;
	logic [SW-1:0]  idx_q;
	logic [SW:0]    probe_cnt_q;
	logic           found_q, free_q;
	logic           rsp_valid_q;
	dhkt_pkg::rsp_beat_t rsp_q, rsp_d;

	logic [7:0]    cur_byte;
	logic [SW-1:0] size_m2, step;
	logic [SW:0]   t_a, t_b, wrap_sum;
	logic [AW-1:0] idx_ext;
	logic [IW-1:0] rd_addr, wr_addr;
	logic          too_long, full, ins_we, rd_free, rd_match;

	assign cur_byte = chunk_q[8*byte_cnt_q[2:0] +: 8];
	assign too_long = (len_q > LEN_MAX);
	assign size_m2  = table_size - SW'(2);
	assign step     = rem_b_q + SW'(1);
	assign t_a      = {rem_a_q, h_q[HW-1]};
	assign t_b      = {rem_b_q, h_q[HW-1]};
	assign wrap_sum = {1'b0, table_size} + {1'b0, idx_q} - {1'b0, step};
	assign idx_ext  = AW'(idx_q);
	assign rd_addr  = idx_ext[IW-1:0];
	assign full     = (count_q >= table_size);
	assign rd_free  = (rd_hash_q == '0);
	assign rd_match = (rd_hash_q == h_q) && (rd_len_q == len_q) && (rd_key_q == key_buf_q);
	assign ins_we   = cmd.finish && !too_long && !found_q && enter_q && !full && free_q;
	assign wr_addr  = cmd.clr_step ? clr_addr_q : rd_addr;

	always_ff @(posedge clk) begin
		if (cmd.clr_step || ins_we) begin
			mem_hash[wr_addr] <= cmd.clr_step ? '0 : h_q;
		end
		if (ins_we) begin
			mem_key[wr_addr] <= key_buf_q;
			mem_len[wr_addr] <= len_q;
			mem_val[wr_addr] <= value_q;
		end
		rd_hash_q <= mem_hash[rd_addr];
		rd_key_q  <= mem_key[rd_addr];
		rd_len_q  <= mem_len[rd_addr];
		rd_val_q  <= mem_val[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			count_q    <= '0;
			key_buf_q  <= '0;
			len_q      <= '0;
			hash_q     <= dhkt_pkg::FNV_BASIS;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_init) begin
				clr_addr_q <= '0;
				count_q    <= '0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + IW'(1);
			end else if (ins_we) begin
				count_q <= count_q + SW'(1);
			end
			if (cmd.absorb && !too_long) begin
				if (len_q == LEN_MAX) begin
					len_q <= LEN_MAX + LW'(1);
				end else begin
					for (int j = 0; j < MAX_KEY_BYTES; j++) begin
						if (len_q == LW'(j)) key_buf_q[8*j +: 8] <= cur_byte;
					end
					len_q  <= len_q + LW'(1);
					hash_q <= (hash_q ^ {24'd0, cur_byte}) * dhkt_pkg::FNV_PRIME;
				end
			end else if (cmd.finish) begin
				key_buf_q <= '0;
				len_q     <= '0;
				hash_q    <= dhkt_pkg::FNV_BASIS;
			end
			if (cmd.finish) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chunk_q    <= req.key_chunk;
			nb_q       <= (req.chunk_bytes > 4'd8) ? 4'd8 : req.chunk_bytes;
			byte_cnt_q <= '0;
			last_q     <= req.key_end;
			enter_q    <= req.opcode;
			value_q    <= req.entry_value;
		end else if (cmd.absorb) begin
			byte_cnt_q <= byte_cnt_q + 4'd1;
		end
		if (cmd.div_init) begin
			h_q       <= (hash_q == '0) ? HW'(1) : hash_q;
			rem_a_q   <= '0;
			rem_b_q   <= '0;
			div_cnt_q <= dhkt_pkg::DIV_CNT_W'(HW - 1);
		end else if (cmd.div_step) begin
			// restoring remainder, one hash bit per cycle for both divisors
			rem_a_q   <= (t_a >= {1'b0, table_size}) ? SW'(t_a - {1'b0, table_size})
				: t_a[SW-1:0];
			rem_b_q   <= (t_b >= {1'b0, size_m2}) ? SW'(t_b - {1'b0, size_m2})
				: t_b[SW-1:0];
			h_q       <= {h_q[HW-2:0], h_q[HW-1]};
			div_cnt_q <= div_cnt_q - dhkt_pkg::DIV_CNT_W'(1);
		end
		if (cmd.home) begin
			idx_q       <= rem_a_q + SW'(1);
			probe_cnt_q <= '0;
		end else if (cmd.next) begin
			idx_q       <= (idx_q <= step) ? wrap_sum[SW-1:0] : idx_q - step;
			probe_cnt_q <= probe_cnt_q + (SW+1)'(1);
		end
		if (cmd.check) begin
			free_q  <= rd_free;
			found_q <= !rd_free && rd_match;
		end
		if (cmd.finish) rsp_q <= rsp_d;
	end

	always_comb begin
		rsp_d = '0;
		priority if (too_long) begin
			rsp_d.status = dhkt_pkg::RSP_TOO_LONG;
		end else if (found_q) begin
			rsp_d.status       = dhkt_pkg::RSP_FOUND;
			rsp_d.slot_index   = idx_q;
			rsp_d.stored_value = rd_val_q;
		end else if (!enter_q) begin
			rsp_d.status = dhkt_pkg::RSP_NOT_FOUND;
		end else if (full || !free_q) begin
			rsp_d.status = dhkt_pkg::RSP_FULL;
		end else begin
			rsp_d.status       = dhkt_pkg::RSP_INSERTED;
			rsp_d.slot_index   = idx_q;
			rsp_d.stored_value = value_q;
		end
	end

	always_comb begin
		stat.clr_done  = (clr_addr_q == IW'(SLOTS - 1));
		stat.abs_done  = (byte_cnt_q == nb_q) || too_long;
		stat.last      = last_q;
		stat.too_long  = too_long;
		stat.div_done  = (div_cnt_q == '0);
		stat.hit       = rd_free || rd_match;
		stat.exhausted = (probe_cnt_q > {1'b0, table_size});
		stat.out_free  = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sim/tb_double_hash_key_table.sv]
module tb_double_hash_key_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 2500;
	localparam int IDLE_LIMIT  = 20000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 req_valid = 0;
	logic                 req_stall;
	dhkt_pkg::req_beat_t  req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1;
	dhkt_pkg::rsp_beat_t  rsp;
	logic                 psel = 0;
	logic                 penable = 0;
	logic                 pwrite = 0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	double_hash_key_table dut (.*);

	always #4 clk = ~clk;

	// table mirror
	bit [31:0]  tsize;
	bit [31:0]  mir_hash [dhkt_pkg::SLOTS_DEF];
	bit [255:0] mir_key [dhkt_pkg::SLOTS_DEF];
	int         mir_len [dhkt_pkg::SLOTS_DEF];
	bit [31:0]  mir_val [dhkt_pkg::SLOTS_DEF];
	int         mir_count;
	bit [255:0] kbuf;
	int         klen;
	bit [31:0]  run_hash;

	dhkt_pkg::req_beat_t  feed_q [$];
	dhkt_pkg::rsp_beat_t  expect_q [$];
	int         err_cnt = 0;
	bit         req_took = 0, rsp_took = 0;
	bit         quiet = 0, hold_go = 0, hold_done = 0;
	int         gap_left = 0, stall_left = 0, hold_left = 0, idle_cycles = 0;

	task automatic report(string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		err_cnt++;
	endtask

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic void clear_mirror();
		foreach (mir_hash[i]) begin
			mir_hash[i] = '0;
			mir_key[i] = '0;
			mir_len[i] = 0;
			mir_val[i] = '0;
		end
		mir_count = 0;
	endfunction

	function automatic void clear_key();
		kbuf = '0;
		klen = 0;
		run_hash = dhkt_pkg::FNV_BASIS;
	endfunction

	function automatic bit slot_hit(bit [31:0] idx, bit [31:0] h);
		return mir_hash[idx] == h && mir_len[idx] == klen && mir_key[idx] == kbuf;
	endfunction

	task automatic absorb_beat(dhkt_pkg::req_beat_t b);
		int n;
		bit [7:0] by;
		bit [31:0] h, idx, stp, cnt;
		bit fnd, fre;
		dhkt_pkg::rsp_beat_t r;
		n = b.chunk_bytes > 8 ? 8 : int'(b.chunk_bytes);
		for (int i = 0; i < n && klen <= dhkt_pkg::MAX_KEY_BYTES_DEF; i++) begin
			by = b.key_chunk[i*8 +: 8];
			if (klen == dhkt_pkg::MAX_KEY_BYTES_DEF) begin
				klen = dhkt_pkg::MAX_KEY_BYTES_DEF + 1;
				break;
			end
			kbuf[klen*8 +: 8] = by;
			klen++;
			run_hash = (run_hash ^ {24'd0, by}) * dhkt_pkg::FNV_PRIME;
		end
		if (!b.key_end)
			return;
		r = '0;
		r.status = dhkt_pkg::RSP_NOT_FOUND;
		if (klen > dhkt_pkg::MAX_KEY_BYTES_DEF) begin
			r.status = dhkt_pkg::RSP_TOO_LONG;
		end else begin
			h = run_hash == 0 ? 32'd1 : run_hash;
			idx = h % tsize + 1;
			fre = mir_hash[idx] == 0;
			fnd = 0;
			if (!fre && slot_hit(idx, h)) begin
				fnd = 1;
			end else if (!fre) begin
				stp = 1 + h % (tsize - 2);
				cnt = 0;
				forever begin
					if (cnt > tsize)
						break;
					cnt++;
					idx = (idx <= stp) ? tsize + idx - stp : idx - stp;
					if (mir_hash[idx] == 0) begin
						fre = 1;
						break;
					end
					if (slot_hit(idx, h)) begin
						fnd = 1;
						break;
					end
				end
			end
			if (fnd) begin
				r.status = dhkt_pkg::RSP_FOUND;
				r.slot_index = idx[dhkt_pkg::SIZE_W-1:0];
				r.stored_value = mir_val[idx];
			end else if (!b.opcode) begin
				r.status = dhkt_pkg::RSP_NOT_FOUND;
			end else if (mir_count >= tsize || !fre) begin
				r.status = dhkt_pkg::RSP_FULL;
			end else begin
				mir_hash[idx] = h;
				mir_key[idx] = kbuf;
				mir_len[idx] = klen;
				mir_val[idx] = b.entry_value;
				mir_count++;
				r.status = dhkt_pkg::RSP_INSERTED;
				r.slot_index = idx[dhkt_pkg::SIZE_W-1:0];
				r.stored_value = b.entry_value;
			end
		end
		clear_key();
		expect_q.push_back(r);
	endtask

	// posedge: acceptance, prediction, checking
	always @(posedge clk) begin
		dhkt_pkg::rsp_beat_t e;
		req_took = arst_n && req_valid && !req_stall;
		rsp_took = arst_n && rsp_valid && !rsp_stall;
		if (req_took)
			absorb_beat(req);
		if (rsp_took) begin
			if (expect_q.size() == 0) begin
				report($sformatf("unexpected result status %0d", rsp.status));
			end else begin
				e = expect_q.pop_front();
				if (rsp.status !== e.status)
					report($sformatf("status %0d, want %0d", rsp.status, e.status));
				if (rsp.slot_index !== e.slot_index)
					report($sformatf("slot %0d, want %0d", rsp.slot_index, e.slot_index));
				if (rsp.stored_value !== e.stored_value)
					report($sformatf("value %h, want %h", rsp.stored_value, e.stored_value));
			end
		end
		idle_cycles = (req_took || rsp_took || (psel && penable)) ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout");
			$display("tb_double_hash_key_table failed");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !req_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 0;
			end else if (feed_q.size() != 0) begin
				req <= feed_q.pop_front();
				req_valid <= 1;
				gap_left = draw_gap();
			end else begin
				req_valid <= 0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1;
			end else begin
				if (rsp_took)
					stall_left = draw_gap();
				if (stall_left > 0) begin
					stall_left--;
					rsp_stall <= 1;
				end else begin
					rsp_stall <= 0;
				end
			end
		end
	end

	task automatic write_size(bit [31:0] v);
		bit [31:0] s;
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= '0;
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		s = v & 32'h3FF;
		tsize = s < 3 ? 32'd3
			: (s > dhkt_pkg::SLOTS_DEF - 1 ? 32'(dhkt_pkg::SLOTS_DEF - 1) : s);
		clear_mirror();
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// split a key into chunks; the final chunk carries key_end
	task automatic send_key(bit [319:0] k, int len, bit op, bit [31:0] v);
		dhkt_pkg::req_beat_t b;
		int pos, n;
		pos = 0;
		do begin
			n = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 8);
			if (n > len - pos)
				n = len - pos;
			b.key_chunk = {$urandom, $urandom};
			for (int i = 0; i < n; i++)
				b.key_chunk[i*8 +: 8] = k[(pos+i)*8 +: 8];
			b.chunk_bytes = (n == 8 && $urandom_range(0, 3) == 0)
				? 4'($urandom_range(9, 15)) : 4'(n);
			pos += n;
			b.key_end = pos >= len && $urandom_range(0, 4) != 0;
			b.opcode = b.key_end ? op : 1'($urandom_range(0, 1));
			b.entry_value = b.key_end ? v : $urandom;
			feed_q.push_back(b);
		end while (!b.key_end);
	endtask

	function automatic bit [319:0] rand_bytes();
		bit [319:0] k;
		for (int i = 0; i < 10; i++)
			k[i*32 +: 32] = $urandom;
		return k;
	endfunction

	task automatic wait_idle();
		while (feed_q.size() != 0 || req_valid || expect_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_phase(int n_items, int n_keys, int max_len);
		bit [319:0] pool_k [];
		int         pool_l [];
		int         j, start;
		pool_k = new[n_keys];
		pool_l = new[n_keys];
		foreach (pool_k[i]) begin
			pool_k[i] = rand_bytes();
			pool_l[i] = $urandom_range(0, max_len);
		end
		start = feed_q.size();
		while (feed_q.size() - start < n_items) begin
			j = $urandom_range(0, n_keys - 1);
			if ($urandom_range(0, 15) == 0)
				send_key(rand_bytes(), $urandom_range(33, 40), 1'($urandom_range(0, 1)),
					$urandom);
			else
				send_key(pool_k[j], pool_l[j], $urandom_range(0, 2) != 0, $urandom);
		end
	endtask

	initial begin
		bit [319:0] k;
		tsize = 32'(dhkt_pkg::SIZE_RESET);
		clear_mirror();
		clear_key();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		k = '1;
		send_key(k, 8, 1, 32'hFFFF_FFFF);
		send_key(k, 8, 0, 0);
		k = '0;
		send_key(k, 8, 1, 0);
		send_key(k, 8, 0, 32'h1234);
		send_key(k, 7, 0, 0);
		send_key(k, 0, 1, 32'h5A5A_A5A5);
		send_key(k, 0, 0, 0);
		k = rand_bytes();
		send_key(k, 32, 1, 32'hA);
		send_key(k, 32, 1, 32'hB);
		send_key(k, 33, 1, 32'hC);
		send_key(k, 40, 0, 0);
		feed_q.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1, 1'b1, 32'h0BAD_F00D});
		feed_q.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'h8, 1'b1, 1'b0, 32'h0});
		wait_idle();

		write_size(32'h0);
		for (int i = 0; i < 6; i++)
			send_key(rand_bytes(), $urandom_range(1, 12), 1, $urandom);
		random_phase(60, 8, 12);
		wait_idle();

		write_size(32'h0000_0009);
		random_phase(80, 14, 10);
		wait_idle();

		write_size(32'hFFFF_FFFF);
		hold_go = 1;
		random_phase(220, 60, 34);
		wait_idle();

		write_size(32'h0000_0007);
		quiet = 1;
		random_phase(100, 10, 20);
		wait_idle();

		write_size(32'h0000_0407);
		quiet = 0;
		random_phase(60, 9, 16);
		wait_idle();

		write_size(32'd5);
		random_phase(60, 8, 8);
		wait_idle();

		write_size(32'd1021);
		random_phase(220, 50, 34);
		wait_idle();

		write_size(32'd3);
		quiet = 1;
		random_phase(60, 5, 8);
		wait_idle();

		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_double_hash_key_table passed");
		else
			$display("tb_double_hash_key_table failed");
		$finish;
	end

endmodule
